>>> hdl/lpff_pkg.sv
`default_nettype none

package lpff_pkg;

    localparam int DEF_CAPACITY     = 4096;
    localparam int DEF_HEADER_BYTES = 6;

    localparam int OPCODE_W = 2;
    localparam int DATA_W   = 8;
    localparam int CHUNK_W  = 13;
    localparam int STATUS_W = 3;
    localparam int FILL_W   = 13;

    // the payload length sits in header bytes 2 to 5, little endian
    localparam int LEN_OFFSET = 2;
    localparam int LEN_BYTES  = 4;
    localparam int LEN_W      = 8 * LEN_BYTES;

    localparam logic [OPCODE_W-1:0] OP_RESERVE = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_PUSH    = 2'd1;
    localparam logic [OPCODE_W-1:0] OP_PULL    = 2'd2;

    localparam logic [STATUS_W-1:0] ST_RESERVED     = 3'd0;
    localparam logic [STATUS_W-1:0] ST_RES_REFUSED  = 3'd1;
    localparam logic [STATUS_W-1:0] ST_STORED       = 3'd2;
    localparam logic [STATUS_W-1:0] ST_PUSH_REFUSED = 3'd3;
    localparam logic [STATUS_W-1:0] ST_DELIVERED    = 3'd4;
    localparam logic [STATUS_W-1:0] ST_NO_FRAME     = 3'd5;

    typedef struct packed {
        logic       capture;
        logic       rd_en;
        logic       rd_len;
        logic [1:0] rd_idx;
        logic       len_capture;
        logic [1:0] cap_idx;
        logic       frame_set;
        logic       finish;
    } t_ctl_cmd;

    typedef struct packed {
        logic [OPCODE_W-1:0] op;
        logic                hdr_needed;
        logic                frame_active;
        logic                len_fits;
        logic                out_free;
    } t_dp_sts;

endpackage

`default_nettype wire

>>> hdl/lpff_channels.sv
`default_nettype none

interface lpff_in_if;
    logic                          valid;
    logic                          ready;
    logic [lpff_pkg::OPCODE_W-1:0] opcode;
    logic [lpff_pkg::DATA_W-1:0]   data_byte;
    logic [lpff_pkg::CHUNK_W-1:0]  chunk_size;

    modport source (output valid, output opcode, output data_byte, output chunk_size,
                    input ready);
    modport sink (input valid, input opcode, input data_byte, input chunk_size,
                  output ready);
endinterface

interface lpff_out_if;
    logic                          valid;
    logic                          ready;
    logic [lpff_pkg::STATUS_W-1:0] status;
    logic [lpff_pkg::DATA_W-1:0]   out_byte;
    logic                          frame_last;
    logic [lpff_pkg::FILL_W-1:0]   fill_level;

    modport source (output valid, output status, output out_byte, output frame_last,
                    output fill_level, input ready);
    modport sink (input valid, input status, input out_byte, input frame_last,
                  input fill_level, output ready);
endinterface

`default_nettype wire

>>> hdl/lpff_datapath.sv
`default_nettype none

module lpff_datapath #(
    parameter int CAPACITY     = lpff_pkg::DEF_CAPACITY,
    parameter int HEADER_BYTES = lpff_pkg::DEF_HEADER_BYTES
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire lpff_pkg::t_ctl_cmd            i_cmd,
    output lpff_pkg::t_dp_sts                  o_sts,
    input  wire logic [lpff_pkg::OPCODE_W-1:0] i_opcode,
    input  wire logic [lpff_pkg::DATA_W-1:0]   i_data_byte,
    input  wire logic [lpff_pkg::CHUNK_W-1:0]  i_chunk_size,
    input  wire logic                          i_out_ready,
    output logic                               o_out_valid,
    output logic [lpff_pkg::STATUS_W-1:0]      o_status,
    output logic [lpff_pkg::DATA_W-1:0]        o_out_byte,
    output logic                               o_frame_last,
    output logic [lpff_pkg::FILL_W-1:0]        o_fill_level
);

    localparam int PTR_W = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int CMP_W = (CNT_W > lpff_pkg::CHUNK_W) ? CNT_W : lpff_pkg::CHUNK_W;
    localparam int LEN_W = lpff_pkg::LEN_W;

    logic [lpff_pkg::DATA_W-1:0] r_ring [CAPACITY];

    logic [lpff_pkg::OPCODE_W-1:0] r_op;
    logic [lpff_pkg::DATA_W-1:0]   r_data;
    logic [lpff_pkg::CHUNK_W-1:0]  r_chunk;
    logic [LEN_W-1:0]              r_len;
    logic [lpff_pkg::DATA_W-1:0]   r_rd_data;

    logic [PTR_W-1:0] r_head, n_head;
    logic [PTR_W-1:0] r_tail, n_tail;
    logic [CNT_W-1:0] r_count, n_count;
    logic [CNT_W-1:0] r_reserved, n_reserved;
    logic [CNT_W-1:0] r_frame_left, n_frame_left;

    logic                          r_out_valid;
    logic [lpff_pkg::STATUS_W-1:0] r_status, n_status;
    logic [lpff_pkg::DATA_W-1:0]   r_out_byte, n_out_byte;
    logic                          r_last, n_last;
    logic [lpff_pkg::FILL_W-1:0]   r_fill;

    logic [CNT_W-1:0] w_free;
    logic             w_chunk_ok;
    logic             w_push_ok;
    logic             w_wr_en;
    logic [LEN_W-1:0] w_count_ext;
    logic [PTR_W:0]   w_len_sum;
    logic [PTR_W-1:0] w_len_addr;
    logic [PTR_W-1:0] w_rd_addr;
    logic [CNT_W-1:0] w_total;

    assign w_free      = CNT_W'(CAPACITY) - (r_count + r_reserved);
    assign w_chunk_ok  = (r_chunk != '0) && (CMP_W'(r_chunk) <= CMP_W'(w_free));
    assign w_push_ok   = (r_reserved != '0) && (r_count < CNT_W'(CAPACITY));
    assign w_count_ext = LEN_W'(r_count);

    // length byte address: head + 2 + index, wrapped once
    assign w_len_sum  = {1'b0, r_head} + (PTR_W + 1)'(lpff_pkg::LEN_OFFSET)
                      + (PTR_W + 1)'(i_cmd.rd_idx);
    assign w_len_addr = (w_len_sum >= (PTR_W + 1)'(CAPACITY))
                      ? PTR_W'(w_len_sum - (PTR_W + 1)'(CAPACITY))
                      : PTR_W'(w_len_sum);
    assign w_rd_addr  = i_cmd.rd_len ? w_len_addr : r_head;

    // total never exceeds the held count when it is loaded
    assign w_total = r_len[CNT_W-1:0] + CNT_W'(HEADER_BYTES);

    assign o_sts.op           = r_op;
    assign o_sts.hdr_needed   = (r_frame_left == '0)
                              && (w_count_ext >= LEN_W'(HEADER_BYTES));
    assign o_sts.frame_active = (r_frame_left != '0) && (r_count != '0);
    assign o_sts.len_fits     = r_len <= (w_count_ext - LEN_W'(HEADER_BYTES));
    assign o_sts.out_free     = !r_out_valid || i_out_ready;

    always_comb begin
        n_head       = r_head;
        n_tail       = r_tail;
        n_count      = r_count;
        n_reserved   = r_reserved;
        n_frame_left = r_frame_left;
        n_status     = lpff_pkg::ST_NO_FRAME;
        n_out_byte   = '0;
        n_last       = 1'b0;
        w_wr_en      = 1'b0;
        case (r_op)
            lpff_pkg::OP_RESERVE: begin
                if (w_chunk_ok) begin
                    n_reserved = r_reserved + CNT_W'(r_chunk);
                    n_status   = lpff_pkg::ST_RESERVED;
                end else begin
                    n_status   = lpff_pkg::ST_RES_REFUSED;
                end
            end
            lpff_pkg::OP_PUSH: begin
                if (w_push_ok) begin
                    w_wr_en    = i_cmd.finish;
                    n_tail     = (r_tail == PTR_W'(CAPACITY - 1)) ? '0 : r_tail + 1'b1;
                    n_count    = r_count + 1'b1;
                    n_reserved = r_reserved - 1'b1;
                    n_status   = lpff_pkg::ST_STORED;
                end else begin
                    n_status   = lpff_pkg::ST_PUSH_REFUSED;
                end
            end
            lpff_pkg::OP_PULL: begin
                if (o_sts.frame_active) begin
                    n_head       = (r_head == PTR_W'(CAPACITY - 1)) ? '0 : r_head + 1'b1;
                    n_count      = r_count - 1'b1;
                    n_frame_left = r_frame_left - 1'b1;
                    n_out_byte   = r_rd_data;
                    n_last       = (r_frame_left == CNT_W'(1));
                    n_status     = lpff_pkg::ST_DELIVERED;
                end else begin
                    n_frame_left = '0;
                end
            end
            default: begin
                n_status = lpff_pkg::ST_NO_FRAME;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_ring[r_tail] <= r_data;
        end
        if (i_cmd.rd_en) begin
            r_rd_data <= r_ring[w_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op    <= i_opcode;
            r_data  <= i_data_byte;
            r_chunk <= i_chunk_size;
        end
        if (i_cmd.len_capture) begin
            r_len[{i_cmd.cap_idx, 3'b000} +: 8] <= r_rd_data;
        end
        if (i_cmd.finish) begin
            r_status   <= n_status;
            r_out_byte <= n_out_byte;
            r_last     <= n_last;
            r_fill     <= lpff_pkg::FILL_W'(n_count);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head       <= '0;
            r_tail       <= '0;
            r_count      <= '0;
            r_reserved   <= '0;
            r_frame_left <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cmd.finish) begin
                r_head       <= n_head;
                r_tail       <= n_tail;
                r_count      <= n_count;
                r_reserved   <= n_reserved;
                r_frame_left <= n_frame_left;
                r_out_valid  <= 1'b1;
            end else begin
                if (i_cmd.frame_set) begin
                    r_frame_left <= w_total;
                end
                if (r_out_valid && i_out_ready) begin
                    r_out_valid <= 1'b0;
                end
            end
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_status     = r_status;
    assign o_out_byte   = r_out_byte;
    assign o_frame_last = r_last;
    assign o_fill_level = r_fill;

endmodule

`default_nettype wire

>>> hdl/lpff_ctrl.sv
`default_nettype none

module lpff_ctrl (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire lpff_pkg::t_dp_sts  i_sts,
    output lpff_pkg::t_ctl_cmd      o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_LEN,
        S_CHECK,
        S_DONE
    } t_state;

    localparam logic [1:0] LAST_IDX = 2'(lpff_pkg::LEN_BYTES - 1);

    t_state     r_state, n_state;
    logic [1:0] r_idx, n_idx;

    always_comb begin
        n_state           = r_state;
        n_idx             = r_idx;
        o_cmd             = '0;
        o_in_ready        = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready    = 1'b1;
                o_cmd.capture = i_in_valid;
                if (i_in_valid) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (i_sts.op == lpff_pkg::OP_PULL && i_sts.hdr_needed) begin
                    // frame start: fetch the length bytes first
                    o_cmd.rd_en  = 1'b1;
                    o_cmd.rd_len = 1'b1;
                    o_cmd.rd_idx = '0;
                    n_idx        = '0;
                    n_state      = S_LEN;
                end else if (i_sts.op == lpff_pkg::OP_PULL && i_sts.frame_active) begin
                    o_cmd.rd_en = 1'b1;
                    n_state     = S_DONE;
                end else if (i_sts.out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            S_LEN: begin
                o_cmd.len_capture = 1'b1;
                o_cmd.cap_idx     = r_idx;
                if (r_idx == LAST_IDX) begin
                    n_state = S_CHECK;
                end else begin
                    o_cmd.rd_en  = 1'b1;
                    o_cmd.rd_len = 1'b1;
                    o_cmd.rd_idx = r_idx + 1'b1;
                    n_idx        = r_idx + 1'b1;
                end
            end
            S_CHECK: begin
                if (i_sts.len_fits) begin
                    o_cmd.frame_set = 1'b1;
                    o_cmd.rd_en     = 1'b1;
                end
                n_state = S_DONE;
            end
            S_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
        end
    end

endmodule

`default_nettype wire

>>> hdl/length_prefixed_frame_fifo.sv
// a reserve, push, unused opcode or pull with fewer held bytes than a header finishes
// straight from the execute state; a pull inside a frame first reads its byte from the
// ring; a pull that has to read a header, complete frame or not, first reads the four
// length bytes through the single registered ring read port and checks the length.
// a new transaction is taken only once the last one has finished; any output stall holds it.
// synchronous active-low reset empties the ring at once; no clearing pass is needed.
`default_nettype none

module length_prefixed_frame_fifo #(
    parameter int CAPACITY     = lpff_pkg::DEF_CAPACITY,
    parameter int HEADER_BYTES = lpff_pkg::DEF_HEADER_BYTES
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    lpff_in_if.sink    i_req,
    lpff_out_if.source o_rsp
);

    lpff_pkg::t_ctl_cmd w_cmd;
    lpff_pkg::t_dp_sts  w_sts;
    logic               w_in_ready;

    lpff_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_req.valid),
        .o_in_ready (w_in_ready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    lpff_datapath #(
        .CAPACITY     (CAPACITY),
        .HEADER_BYTES (HEADER_BYTES)
    ) u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .o_sts        (w_sts),
        .i_opcode     (i_req.opcode),
        .i_data_byte  (i_req.data_byte),
        .i_chunk_size (i_req.chunk_size),
        .i_out_ready  (o_rsp.ready),
        .o_out_valid  (o_rsp.valid),
        .o_status     (o_rsp.status),
        .o_out_byte   (o_rsp.out_byte),
        .o_frame_last (o_rsp.frame_last),
        .o_fill_level (o_rsp.fill_level)
    );

    assign i_req.ready = w_in_ready;

endmodule

`default_nettype wire
